[rtl/skpt_pkg.sv]
`timescale 1ns / 1ps

package skpt_pkg;

  // key and counter widths
  localparam int KEY_BITS       = 64;
  localparam int COUNT_BITS     = 32;
  localparam int SKIP_BITS      = 32;
  localparam int REASON_BITS    = 2;

  // configuration port
  localparam int SPACING_BITS   = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPACING_LOG2 = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_PARITY = 2'd1;

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 5'd20;
  localparam logic [SPACING_BITS-1:0] MAX_SPACING   = 5'd24;

  // reason codes on the result channel
  localparam logic [REASON_BITS-1:0] REASON_FIRST   = 2'd0;
  localparam logic [REASON_BITS-1:0] REASON_FAR     = 2'd1;
  localparam logic [REASON_BITS-1:0] REASON_RUN_END = 2'd2;

  // limb-serial power unit: d^5 built from 24-bit limbs
  localparam int LIMB_BITS     = 24;
  localparam int NUM_LIMBS     = 5;
  localparam int LIMB_IDX_BITS = 3;
  localparam int PASS_BITS     = 3;
  localparam int POW_PASSES    = 4;
  localparam int WIDE_BITS     = NUM_LIMBS * LIMB_BITS;
  localparam int SHIFT_BITS    = 7;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // controller to datapath
  typedef struct packed {
    logic                     load_key;
    logic                     first;
    logic                     far_emit;
    logic                     plain_quiet;
    logic                     run_extend;
    logic                     fail_prev;
    logic                     fail_key;
    logic                     gsq;
    logic                     pow_step;
    logic                     pow_last;
    logic [LIMB_IDX_BITS-1:0] limb;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seen_first;
    logic in_run;
    logic parity;
    logic prev_far;
    logic anchor_far;
    logic run_cont;
    logic out_free;
  } status_t;

endpackage

[rtl/skpt_ctrl.sv]
`timescale 1ns / 1ps

module skpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  skpt_pkg::status_t status,
  output skpt_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_GSQ   = 4'd2;
  localparam logic [3:0] S_POW   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_FAIL  = 4'd5;
  localparam logic [3:0] S_PLAIN = 4'd6;
  localparam logic [3:0] S_FAR   = 4'd7;
  localparam logic [3:0] S_FIRST = 4'd8;

  logic [3:0]                     state, state_next;
  logic [skpt_pkg::PASS_BITS-1:0] pass, pass_next;
  logic [1:0]                     limb, limb_next;
  logic                           pow_last;

  assign in_ready = (state == S_IDLE);
  assign pow_last = ({1'b0, limb} == pass - 3'd1);

  // next state and commands
  always_comb begin
    state_next   = state;
    pass_next    = pass;
    limb_next    = limb;
    cmd          = '0;
    cmd.limb     = {1'b0, limb};
    cmd.pow_last = pow_last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.seen_first) begin
          state_next = S_FIRST;
        end else if (status.in_run) begin
          state_next = status.anchor_far ? S_FAIL : S_GSQ;
        end else begin
          state_next = S_PLAIN;
        end
      end
      S_GSQ: begin
        cmd.gsq    = 1'b1;
        pass_next  = 3'd1;
        limb_next  = 2'd0;
        state_next = S_POW;
      end
      S_POW: begin
        cmd.pow_step = 1'b1;
        if (pow_last) begin
          limb_next = 2'd0;
          if (pass == 3'(skpt_pkg::POW_PASSES)) begin
            state_next = S_CMP;
          end else begin
            pass_next = pass + 3'd1;
          end
        end else begin
          limb_next = limb + 2'd1;
        end
      end
      S_CMP: begin
        if (status.run_cont) begin
          cmd.run_extend = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_FAIL;
        end
      end
      S_FAIL: begin
        if (status.out_free) begin
          if (!status.parity) begin
            cmd.fail_prev = 1'b1;
            state_next    = status.prev_far ? S_FAR : S_IDLE;
          end else begin
            cmd.fail_key = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_PLAIN: begin
        if (status.prev_far) begin
          if (status.out_free) begin
            cmd.far_emit = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.plain_quiet = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FAR: begin
        if (status.out_free) begin
          cmd.far_emit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FIRST: begin
        if (status.out_free) begin
          cmd.first  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 3'd1;
      limb  <= 2'd0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      limb  <= limb_next;
    end
  end

  // multiplier limb always below the current pass length
  a_limb_in_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.pow_step |-> ({1'b0, limb} < pass))
    else $error("limb index beyond pass length");

  // compare only follows the last power step
  a_cmp_after_pow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_POW))
    else $error("compare entered without power pass");

  // at most one state update command per cycle
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.first, cmd.far_emit, cmd.plain_quiet, cmd.run_extend,
              cmd.fail_prev, cmd.fail_key}))
    else $error("several update commands in one cycle");

endmodule

[rtl/skpt_dp.sv]
`timescale 1ns / 1ps

module skpt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skpt_pkg::cmd_t                       cmd,
  output skpt_pkg::status_t                    status,
  input  logic [skpt_pkg::KEY_BITS-1:0]        point_key,
  input  logic                                 cfg_valid,
  input  logic [skpt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [skpt_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [skpt_pkg::KEY_BITS-1:0]        kept_key,
  output logic [skpt_pkg::REASON_BITS-1:0]     keep_reason,
  output logic [skpt_pkg::SKIP_BITS-1:0]       skipped_count,
  output logic                                 last_of_run
);

  localparam int KB = skpt_pkg::KEY_BITS;
  localparam int LB = skpt_pkg::LIMB_BITS;
  localparam int WB = skpt_pkg::WIDE_BITS;
  localparam logic [skpt_pkg::COUNT_BITS-1:0] COUNT_ONE =
    {{(skpt_pkg::COUNT_BITS-1){1'b0}}, 1'b1};

  // control state
  logic                              seen_first;
  logic                              in_run;
  logic                              parity;
  logic [skpt_pkg::SPACING_BITS-1:0] spacing;

  // payload state
  logic [KB-1:0]                   key_r;
  logic [KB-1:0]                   previous_key;
  logic [KB-1:0]                   anchor_key;
  logic [LB-1:0]                   run_gap;
  logic [skpt_pkg::COUNT_BITS-1:0] run_length;

  // power unit
  logic [LB-1:0]   pw [skpt_pkg::NUM_LIMBS];
  logic [LB-1:0]   carry;
  logic [LB-1:0]   d_r;
  logic [2*LB-1:0] g2;
  logic [WB-1:0]   rhs;
  logic [WB-1:0]   pw_flat;
  logic [LB-1:0]   mul_a, mul_b;
  logic [2*LB-1:0] prod, sum;

  logic [skpt_pkg::SPACING_BITS-1:0] s_eff;
  logic [skpt_pkg::SHIFT_BITS-1:0]   sh3;
  logic [KB-1:0]                     far_mask;
  logic [KB-1:0]                     dist_prev, dist_anchor;
  logic                              prev_far, prev_nonzero, anchor_far;
  logic                              open_run, emit, take_key;
  logic [skpt_pkg::COUNT_BITS-1:0]   cnt_prev;

  // distances and spacing tests
  assign s_eff        = (spacing > skpt_pkg::MAX_SPACING) ? skpt_pkg::MAX_SPACING : spacing;
  assign sh3          = {2'b00, s_eff} + {1'b0, s_eff, 1'b0};
  assign far_mask     = {KB{1'b1}} << s_eff;
  assign dist_prev    = key_r - previous_key;
  assign dist_anchor  = key_r - anchor_key;
  assign prev_far     = |(dist_prev & far_mask);
  assign prev_nonzero = |dist_prev;
  assign anchor_far   = |(dist_anchor & far_mask);

  assign open_run = (cmd.plain_quiet | cmd.fail_prev) & ~prev_far & prev_nonzero;
  assign emit     = cmd.first | cmd.far_emit | cmd.fail_prev | cmd.fail_key;
  assign take_key = cmd.first | cmd.far_emit | cmd.plain_quiet | cmd.run_extend |
                    cmd.fail_prev | cmd.fail_key;
  assign cnt_prev = (run_length != skpt_pkg::COUNT_MAX) ? run_length - COUNT_ONE : run_length;

  // shared 24x24 multiplier
  assign mul_a = cmd.gsq ? run_gap : pw[cmd.limb];
  assign mul_b = cmd.gsq ? run_gap : d_r;
  assign prod  = mul_a * mul_b;
  assign sum   = prod + {{LB{1'b0}}, carry};

  always_comb begin
    for (int i = 0; i < skpt_pkg::NUM_LIMBS; i++) begin
      pw_flat[i*LB +: LB] = pw[i];
    end
  end

  // status back to the controller
  assign status.seen_first = seen_first;
  assign status.in_run     = in_run;
  assign status.parity     = parity;
  assign status.prev_far   = prev_far;
  assign status.anchor_far = anchor_far;
  assign status.run_cont   = (pw_flat <= rhs);
  assign status.out_free   = ~out_valid | out_ready;

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
      in_run     <= 1'b0;
      parity     <= 1'b0;
      spacing    <= skpt_pkg::SPACING_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == skpt_pkg::REG_SPACING_LOG2) begin
          spacing <= cfg_data;
        end
        if (cfg_index == skpt_pkg::REG_START_PARITY) begin
          parity <= cfg_data[0];
        end
      end
      if (cmd.first) begin
        seen_first <= 1'b1;
      end
      if (cmd.plain_quiet || cmd.fail_prev) begin
        in_run <= open_run;
      end else if (cmd.fail_key) begin
        in_run <= 1'b0;
      end
      if (cmd.fail_prev) begin
        parity <= 1'b1;
      end else if (cmd.fail_key) begin
        parity <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // key and run bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= point_key;
    end
    if (take_key) begin
      previous_key <= key_r;
    end
    if (open_run) begin
      anchor_key <= previous_key;
      run_gap    <= dist_prev[LB-1:0];
      run_length <= COUNT_ONE;
    end else if (cmd.run_extend && run_length != skpt_pkg::COUNT_MAX) begin
      run_length <= run_length + COUNT_ONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.first) begin
      kept_key      <= key_r;
      keep_reason   <= skpt_pkg::REASON_FIRST;
      skipped_count <= '0;
      last_of_run   <= 1'b1;
    end else if (cmd.far_emit) begin
      kept_key      <= key_r;
      keep_reason   <= skpt_pkg::REASON_FAR;
      skipped_count <= '0;
      last_of_run   <= 1'b1;
    end else if (cmd.fail_prev) begin
      kept_key      <= previous_key;
      keep_reason   <= skpt_pkg::REASON_RUN_END;
      skipped_count <= cnt_prev;
      last_of_run   <= ~prev_far;
    end else if (cmd.fail_key) begin
      kept_key      <= key_r;
      keep_reason   <= skpt_pkg::REASON_RUN_END;
      skipped_count <= run_length;
      last_of_run   <= 1'b1;
    end
  end

  // power unit: g^2, then d^2..d^5 one limb per cycle
  always_ff @(posedge clk) begin
    rhs <= {{(WB-2*LB){1'b0}}, g2} << sh3;
    if (cmd.gsq) begin
      g2    <= prod;
      d_r   <= dist_anchor[LB-1:0];
      carry <= '0;
      for (int i = 0; i < skpt_pkg::NUM_LIMBS; i++) begin
        pw[i] <= (i == 0) ? dist_anchor[LB-1:0] : '0;
      end
    end else if (cmd.pow_step) begin
      pw[cmd.limb] <= sum[LB-1:0];
      if (cmd.pow_last) begin
        pw[cmd.limb + 3'd1] <= sum[2*LB-1:LB];
        carry               <= '0;
      end else begin
        carry <= sum[2*LB-1:LB];
      end
    end
  end

  // results only load into a free or draining register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting item");

  // a run is only open after the first key
  a_run_seen: assert property (@(posedge clk) disable iff (rst)
    in_run |-> seen_first)
    else $error("skip run open before first key");

  // skip count only on run-end results
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && keep_reason != skpt_pkg::REASON_RUN_END) |-> (skipped_count == '0))
    else $error("nonzero skip count outside run end");

endmodule

[rtl/sorted_key_point_thinning_unit.sv]
`timescale 1ns / 1ps

// channel  signals                                   direction
// in       in_valid, in_ready, point_key             item in
// out      out_valid, out_ready, kept_key,           item out
//          keep_reason, skipped_count, last_of_run
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// one item at a time; a first or plain key, with or without a far result, takes no
// multiplier; a key inside a skip run is settled by the d^5 compare on the
// shared 24x24 multiplier (g^2 first, then limb steps for d^2..d^5, then the compare)
// a key at least 2^S past the anchor skips the multiplier and can give two results
// rst is synchronous; config is accepted every cycle, cfg_ready stays high
// a stalled result holds the controller before its emit; the input side waits

module sorted_key_point_thinning_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [skpt_pkg::KEY_BITS-1:0]        point_key,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [skpt_pkg::KEY_BITS-1:0]        kept_key,
  output logic [skpt_pkg::REASON_BITS-1:0]     keep_reason,
  output logic [skpt_pkg::SKIP_BITS-1:0]       skipped_count,
  output logic                                 last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [skpt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [skpt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  skpt_pkg::cmd_t    cmd;
  skpt_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  skpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // state, power unit and result register
  skpt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .point_key     (point_key),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .kept_key      (kept_key),
    .keep_reason   (keep_reason),
    .skipped_count (skipped_count),
    .last_of_run   (last_of_run)
  );

endmodule
